// ===== design/kpds_pkg.sv =====
package kpds_pkg;

  localparam int unsigned CodeW   = 10;
  localparam int unsigned LevelW  = 16;
  localparam int unsigned PByteW  = 8;
  localparam int unsigned DutyW   = 10;
  localparam int unsigned LedW    = 4;
  localparam int unsigned ProdW   = 2 * LevelW + 1;
  localparam int unsigned DutySh  = 22;

  localparam logic [LevelW-1:0] KnobTop   = 16'hffc0;
  localparam logic [LevelW-1:0] FlipTop   = 16'hffff;
  localparam logic [LevelW-1:0] PeriodMin = 16'h1000;
  localparam logic [LevelW-1:0] PeriodMax = 16'hff00;
  localparam logic [LevelW-1:0] HighReset = 16'h8000;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_FREQ = 2'd1,
    MODE_DUTY = 2'd2
  } mode_e;

  typedef struct packed {
    mode_e             mode;
    logic [LevelW-1:0] period;
    logic [LevelW-1:0] high;
  } state_t;

  typedef struct packed {
    logic              period_load;
    logic [PByteW-1:0] period_byte;
    logic              duty_load;
    logic [DutyW-1:0]  duty_value;
    logic              led_load;
    logic [LedW-1:0]   led_bits;
  } result_t;

endpackage

// ===== design/kpds_calc.sv =====
// Next-state and result logic for one knob sample.
module kpds_calc (
  input  kpds_pkg::state_t              state_i,
  input  logic                          s1_pressed_i,
  input  logic                          s2_pressed_i,
  input  logic [kpds_pkg::CodeW-1:0]    adc_code_i,
  output kpds_pkg::state_t              state_o,
  output kpds_pkg::result_t             result_o
);

  logic [kpds_pkg::LevelW-1:0] knob;
  logic [kpds_pkg::LevelW-1:0] flip;
  logic [kpds_pkg::LevelW-1:0] clamped;
  logic [kpds_pkg::LevelW-1:0] value;
  logic [kpds_pkg::LevelW:0]   period_p1;
  logic [kpds_pkg::ProdW-1:0]  prod;
  logic                        changed;
  kpds_pkg::mode_e             mode;

  assign knob = kpds_pkg::KnobTop
              - {adc_code_i, {(kpds_pkg::LevelW - kpds_pkg::CodeW){1'b0}}};
  assign flip = kpds_pkg::FlipTop - knob;

  always_comb begin
    if (flip < kpds_pkg::PeriodMin) begin
      clamped = kpds_pkg::PeriodMin;
    end else if (flip > kpds_pkg::PeriodMax) begin
      clamped = kpds_pkg::PeriodMax;
    end else begin
      clamped = flip;
    end
  end

  always_comb begin
    if (s1_pressed_i) begin
      mode = kpds_pkg::MODE_FREQ;
    end else if (s2_pressed_i) begin
      mode = kpds_pkg::MODE_DUTY;
    end else begin
      mode = state_i.mode;
    end
  end

  always_comb begin
    state_o      = state_i;
    state_o.mode = mode;
    value        = knob;
    changed      = 1'b0;
    unique case (mode)
      kpds_pkg::MODE_FREQ: begin
        value   = clamped;
        changed = (state_i.period != clamped);
        if (changed) begin
          state_o.period = clamped;
        end
      end
      kpds_pkg::MODE_DUTY: begin
        value   = knob;
        changed = (state_i.high != knob);
        if (changed) begin
          state_o.high = knob;
        end
      end
      default: begin
        value   = knob;
        changed = 1'b0;
      end
    endcase
  end

  assign period_p1 = {1'b0, state_o.period} + {{kpds_pkg::LevelW{1'b0}}, 1'b1};
  assign prod      = {{(kpds_pkg::LevelW + 1){1'b0}}, state_o.high}
                   * {{kpds_pkg::LevelW{1'b0}}, period_p1};

  always_comb begin
    result_o = '0;
    if (mode != kpds_pkg::MODE_FREQ && mode != kpds_pkg::MODE_DUTY) begin
      // idle: force duty to zero on every sample
      result_o.duty_load = 1'b1;
    end else if (changed) begin
      result_o.period_load = 1'b1;
      result_o.period_byte =
        state_o.period[kpds_pkg::LevelW-1 -: kpds_pkg::PByteW];
      result_o.duty_load   = 1'b1;
      result_o.duty_value  = prod[kpds_pkg::DutySh +: kpds_pkg::DutyW];
      result_o.led_load    = 1'b1;
      result_o.led_bits    = value[kpds_pkg::LevelW-1 -: kpds_pkg::LedW];
    end
  end

endmodule

// ===== design/knob_pwm_period_duty_setter_unit.sv =====
// Channel  Dir  Fields (tdata / tuser, lowest bit first)
// s_axis   in   tdata: adc_code[9:0], zero pad to 16 | tuser: s1_pressed, s2_pressed
// m_axis   out  tdata: period_byte[7:0], duty_value[9:0], led_bits[3:0], pad to 24
//               tuser: period_load, duty_load, led_load
//
// The sample sits in the input register, and the result register loads from it
// once the output stage can advance. One sample per cycle sustained while the
// output is not stalled; mode, clamp, state update and multiply are combinational.
// Reset clears mode, period (0) and high time (0x8000) and empties both stages.
// A stalled result holds its stage; input is still taken while the stage ahead
// can advance in the same cycle.
module knob_pwm_period_duty_setter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // adc_code[9:0], pad
  input  logic [1:0]  s_axis_tuser,   // s1_pressed, s2_pressed
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // period_byte, duty_value, led_bits, pad
  output logic [2:0]  m_axis_tuser    // period_load, duty_load, led_load
);

  logic                          in_vld_q;
  logic                          s1_q;
  logic                          s2_q;
  logic [kpds_pkg::CodeW-1:0]    code_q;
  logic                          out_vld_q;
  kpds_pkg::result_t             res_q;
  kpds_pkg::result_t             res_d;
  kpds_pkg::state_t              state_q;
  kpds_pkg::state_t              state_d;
  logic                          out_adv;
  logic                          in_take;

  assign out_adv       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || out_adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  kpds_calc u_calc (
    .state_i      (state_q),
    .s1_pressed_i (s1_q),
    .s2_pressed_i (s2_q),
    .adc_code_i   (code_q),
    .state_o      (state_d),
    .result_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q       <= 1'b0;
      out_vld_q      <= 1'b0;
      state_q.mode   <= kpds_pkg::MODE_NONE;
      state_q.period <= '0;
      state_q.high   <= kpds_pkg::HighReset;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (out_adv) begin
        out_vld_q <= in_vld_q;
        if (in_vld_q) begin
          state_q <= state_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q   <= s_axis_tuser[0];
      s2_q   <= s_axis_tuser[1];
      code_q <= s_axis_tdata[kpds_pkg::CodeW-1:0];
    end
    if (out_adv && in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, res_q.led_bits, res_q.duty_value, res_q.period_byte};
  assign m_axis_tuser  = {res_q.led_load, res_q.duty_load, res_q.period_load};

endmodule
